// File: src/iss_pkg.sv
`default_nettype none

package iss_pkg;

  // Table depths and the address widths that follow from them.
  localparam int unsigned DATA_DEPTH  = 1024;
  localparam int unsigned INDEX_DEPTH = 16;
  localparam int unsigned DATA_AW     = $clog2(DATA_DEPTH);
  localparam int unsigned INDEX_AW    = $clog2(INDEX_DEPTH);

  // Field widths.
  localparam int unsigned OPCODE_W = 2;
  localparam int unsigned SLOT_W   = 10;
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned START_W  = 10;
  localparam int unsigned POS_W    = 10;
  localparam int unsigned DCOUNT_W = 11;
  localparam int unsigned ICOUNT_W = 5;

  // Stream widths, padded to whole bytes.
  localparam int unsigned IN_FIELDS_W  = OPCODE_W + SLOT_W + KEY_W + START_W;
  localparam int unsigned IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int unsigned OUT_FIELDS_W = 1 + POS_W;
  localparam int unsigned OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 11;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DATA_COUNT  = 1'b0,
    REG_INDEX_COUNT = 1'b1
  } cfg_reg_t;

  // Operation codes.
  typedef enum logic [OPCODE_W-1:0] {
    OP_WRITE_DATA  = 2'd0,
    OP_WRITE_INDEX = 2'd1,
    OP_SEARCH      = 2'd2,
    OP_NONE        = 2'd3
  } opcode_t;

endpackage

`default_nettype wire

// File: src/indexed_sequential_search.sv
`default_nettype none

// Channel  Signals                        Direction  Content
// in_      in_tvalid/in_tready/in_tdata   input      table writes and searches
// out_     out_tvalid/out_tready/out_tdata output    one result per search
// cfg_     cfg_we/cfg_index/cfg_data      input      data_count, index_count
//
// A search first checks the key against the first and last data entries in use, then walks
// the M index entries in use and compares L entries of the chosen segment; keys out of range
// finish after the range check and keys below every index key after the index walk. One key
// comparator serves the range check, the index walk and the segment scan; the data table has
// one read port. A finished result waits for a free output register, then the next is taken.
// Reset is synchronous and clears the sequencer, the output valid and both counts (to 1).
module indexed_sequential_search (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // opcode [1:0], slot [11:2], key_value [43:12], start_position [53:44], zeros
  input  wire logic [iss_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  // found [0], position [10:1], zeros
  output logic [iss_pkg::OUT_TDATA_W-1:0]         out_tdata,
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  input  wire logic                               cfg_we,
  input  wire logic [iss_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [iss_pkg::CFG_DATA_W-1:0]     cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LO,
    S_HI,
    S_RANGE,
    S_IDX,
    S_SEG,
    S_SCAN,
    S_DONE
  } state_t;

  // Unpacked input fields.
  logic [iss_pkg::OPCODE_W-1:0]     in_opcode;
  logic [iss_pkg::SLOT_W-1:0]       in_slot;
  logic signed [iss_pkg::KEY_W-1:0] in_key_value;
  logic [iss_pkg::START_W-1:0]      in_start_position;

  assign in_opcode         = in_tdata[1:0];
  assign in_slot           = in_tdata[11:2];
  assign in_key_value      = in_tdata[43:12];
  assign in_start_position = in_tdata[53:44];

  // Storage.
  logic signed [iss_pkg::KEY_W-1:0]   data_mem [iss_pkg::DATA_DEPTH];
  logic signed [iss_pkg::KEY_W-1:0]   index_keys_r [iss_pkg::INDEX_DEPTH];
  logic [iss_pkg::START_W-1:0]        index_starts_r [iss_pkg::INDEX_DEPTH];
  logic signed [iss_pkg::KEY_W-1:0]   rdata_r;

  // Control and working registers.
  state_t                             state_r;
  logic [iss_pkg::DCOUNT_W-1:0]       data_count_r;
  logic [iss_pkg::ICOUNT_W-1:0]       index_count_r;
  logic signed [iss_pkg::KEY_W-1:0]   key_r;
  logic                               below_r;
  logic [iss_pkg::INDEX_AW-1:0]       idx_r;
  logic [iss_pkg::INDEX_AW-1:0]       sel_r;
  logic                               have_r;
  logic [iss_pkg::DCOUNT_W-1:0]       pos_r;
  logic [iss_pkg::DCOUNT_W-1:0]       end_r;
  logic [iss_pkg::DATA_AW-1:0]        cmp_pos_r;
  logic                               cmp_vld_r;
  logic                               res_found_r;
  logic [iss_pkg::POS_W-1:0]          res_pos_r;
  logic                               out_valid_r;
  logic                               out_found_r;
  logic [iss_pkg::POS_W-1:0]          out_pos_r;

  logic                               in_fire;
  logic                               data_we;
  logic [iss_pkg::DATA_AW-1:0]        mem_raddr;
  logic [iss_pkg::DCOUNT_W-1:0]       n_used;
  logic [iss_pkg::ICOUNT_W-1:0]       m_used;
  logic [iss_pkg::INDEX_AW-1:0]       m_last;
  logic [iss_pkg::ICOUNT_W-1:0]       sel_next_wide;
  logic [iss_pkg::INDEX_AW-1:0]       sel_next;
  logic [iss_pkg::DCOUNT_W-1:0]       seg_end_raw;
  logic [iss_pkg::DCOUNT_W-1:0]       seg_end;
  logic                               out_free;
  logic signed [iss_pkg::KEY_W-1:0]   cmp_a;
  logic signed [iss_pkg::KEY_W-1:0]   cmp_b;
  logic                               cmp_lt;
  logic                               cmp_eq;

  assign in_tready  = (state_r == S_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(iss_pkg::OUT_TDATA_W - iss_pkg::OUT_FIELDS_W){1'b0}},
                       out_pos_r, out_found_r};
  assign out_free   = !out_valid_r || out_tready;

  // Counts in use, clamped to 1..depth.
  always_comb begin
    if (data_count_r == '0) begin
      n_used = iss_pkg::DCOUNT_W'(1);
    end else if (data_count_r > iss_pkg::DCOUNT_W'(iss_pkg::DATA_DEPTH)) begin
      n_used = iss_pkg::DCOUNT_W'(iss_pkg::DATA_DEPTH);
    end else begin
      n_used = data_count_r;
    end
    if (index_count_r == '0) begin
      m_used = iss_pkg::ICOUNT_W'(1);
    end else if (index_count_r > iss_pkg::ICOUNT_W'(iss_pkg::INDEX_DEPTH)) begin
      m_used = iss_pkg::ICOUNT_W'(iss_pkg::INDEX_DEPTH);
    end else begin
      m_used = index_count_r;
    end
  end

  assign m_last = iss_pkg::INDEX_AW'(m_used - iss_pkg::ICOUNT_W'(1));

  // Segment end (exclusive): next entry's start, or the data count, clamped.
  assign sel_next_wide = iss_pkg::ICOUNT_W'(sel_r) + iss_pkg::ICOUNT_W'(1);
  assign sel_next      = sel_next_wide[iss_pkg::INDEX_AW-1:0];

  always_comb begin
    if (sel_next_wide < m_used) begin
      seg_end_raw = iss_pkg::DCOUNT_W'(index_starts_r[sel_next]);
    end else begin
      seg_end_raw = n_used;
    end
    seg_end = (seg_end_raw > n_used) ? n_used : seg_end_raw;
  end

  // Shared key comparator: operands chosen by the current step.
  always_comb begin
    case (state_r)
      S_HI: begin
        cmp_a = key_r;
        cmp_b = rdata_r;
      end
      S_IDX: begin
        cmp_a = key_r;
        cmp_b = index_keys_r[idx_r];
      end
      default: begin
        cmp_a = rdata_r;
        cmp_b = key_r;
      end
    endcase
  end

  assign cmp_lt = (cmp_a < cmp_b);
  assign cmp_eq = (cmp_a == cmp_b);

  // Data table read address for the current step.
  always_comb begin
    case (state_r)
      S_LO:    mem_raddr = '0;
      S_HI:    mem_raddr = iss_pkg::DATA_AW'(n_used - iss_pkg::DCOUNT_W'(1));
      default: mem_raddr = pos_r[iss_pkg::DATA_AW-1:0];
    endcase
  end

  assign data_we = in_fire && (in_opcode == iss_pkg::OP_WRITE_DATA) &&
                   (iss_pkg::DCOUNT_W'(in_slot) < iss_pkg::DCOUNT_W'(iss_pkg::DATA_DEPTH));

  // Data table: one write port and one registered read port.
  always_ff @(posedge clk) begin
    if (data_we) begin
      data_mem[in_slot[iss_pkg::DATA_AW-1:0]] <= in_key_value;
    end
    rdata_r <= data_mem[mem_raddr];
  end

  // Index table writes.
  always_ff @(posedge clk) begin
    if (in_fire && (in_opcode == iss_pkg::OP_WRITE_INDEX) &&
        (in_slot < iss_pkg::SLOT_W'(iss_pkg::INDEX_DEPTH))) begin
      index_keys_r[in_slot[iss_pkg::INDEX_AW-1:0]]   <= in_key_value;
      index_starts_r[in_slot[iss_pkg::INDEX_AW-1:0]] <= in_start_position;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_count_r  <= iss_pkg::DCOUNT_W'(1);
      index_count_r <= iss_pkg::ICOUNT_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        iss_pkg::REG_DATA_COUNT:  data_count_r  <= cfg_data;
        iss_pkg::REG_INDEX_COUNT: index_count_r <= cfg_data[iss_pkg::ICOUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Search sequencer and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      cmp_vld_r   <= 1'b0;
      have_r      <= 1'b0;
    end else begin
      if (out_valid_r && out_tready && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_fire && (in_opcode == iss_pkg::OP_SEARCH)) begin
            key_r   <= in_key_value;
            state_r <= S_LO;
          end
        end
        S_LO: begin
          state_r <= S_HI;
        end
        // First data entry is now in the read register.
        S_HI: begin
          below_r <= cmp_lt;
          state_r <= S_RANGE;
        end
        // Last data entry in use is now in the read register.
        S_RANGE: begin
          idx_r  <= '0;
          have_r <= 1'b0;
          if (below_r || cmp_lt) begin
            res_found_r <= 1'b0;
            res_pos_r   <= '0;
            state_r     <= S_DONE;
          end else begin
            state_r <= S_IDX;
          end
        end
        // Walk the index, keeping the last entry whose key is at most the search key.
        S_IDX: begin
          if (!cmp_lt) begin
            sel_r  <= idx_r;
            have_r <= 1'b1;
          end
          if (idx_r == m_last) begin
            state_r <= S_SEG;
          end else begin
            idx_r <= idx_r + iss_pkg::INDEX_AW'(1);
          end
        end
        S_SEG: begin
          cmp_vld_r <= 1'b0;
          if (!have_r) begin
            res_found_r <= 1'b0;
            res_pos_r   <= '0;
            state_r     <= S_DONE;
          end else begin
            pos_r   <= iss_pkg::DCOUNT_W'(index_starts_r[sel_r]);
            end_r   <= seg_end;
            state_r <= S_SCAN;
          end
        end
        // One read issued and one entry compared per cycle.
        S_SCAN: begin
          if (cmp_vld_r && cmp_eq) begin
            cmp_vld_r   <= 1'b0;
            res_found_r <= 1'b1;
            res_pos_r   <= cmp_pos_r;
            state_r     <= S_DONE;
          end else if (pos_r >= end_r) begin
            cmp_vld_r   <= 1'b0;
            res_found_r <= 1'b0;
            res_pos_r   <= '0;
            state_r     <= S_DONE;
          end else begin
            cmp_vld_r <= 1'b1;
            cmp_pos_r <= pos_r[iss_pkg::DATA_AW-1:0];
            pos_r     <= pos_r + iss_pkg::DCOUNT_W'(1);
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_found_r <= res_found_r;
            out_pos_r   <= res_pos_r;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
